FILE: sv/h264ns_pkg.sv
// Shared types and constants for the H.264 start code NAL splitter.
`timescale 1ns / 1ps

package h264ns_pkg;

    localparam int MAX_SAMPLE_BYTES = 1048576;
    localparam int POS_W            = $clog2(MAX_SAMPLE_BYTES + 1);
    localparam int FIELD_W          = 20;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] TYPE_MASK  = 8'h1f;
    localparam logic [7:0] TYPE_AUD   = 8'h09;
    localparam logic [7:0] TYPE_IDR   = 8'h05;
    localparam logic [2:0] SKIP_AFTER = 3'd5;
    localparam int         WIN_LAST   = 5;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] index;
        logic               eos;
        logic               key;
        logic [FIELD_W-1:0] count;
    } t_result;

    // One queue entry holds everything a single input byte produced.
    typedef struct packed {
        logic    has_frag;
        logic    has_end;
        t_result frag;
        t_result fin;
    } t_entry;

endpackage

FILE: sv/h264ns_front.sv
// Front end: byte window, start code detection and fragment bookkeeping.
`timescale 1ns / 1ps

module h264ns_front import h264ns_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last_byte,
    input  logic         i_clean_point,
    output logic         o_push,
    output t_entry       o_entry
);

    logic [7:0]         r_win [0:WIN_LAST-1];
    logic [POS_W-1:0]   r_pos;
    logic [2:0]         r_skip;
    logic [FIELD_W-1:0] r_fcnt;
    logic [FIELD_W-1:0] r_open;
    logic               r_idr;

    logic [7:0]         w [0:WIN_LAST];
    logic               in_range;
    logic               checked;
    logic               scan;
    logic               p4;
    logic               p3;
    logic               found;
    logic [7:0]         hdr;
    logic [FIELD_W-1:0] c_pos;
    logic [POS_W-1:0]   n_pos;
    logic [2:0]         n_skip;
    logic [FIELD_W-1:0] n_fcnt;
    logic [FIELD_W-1:0] n_open;
    logic               n_idr;
    logic               key;

    always_comb begin
        for (int k = 0; k < WIN_LAST; k++) begin
            w[k] = r_win[k];
        end
        w[WIN_LAST] = i_data_byte;
    end

    assign in_range = (r_pos < POS_W'(MAX_SAMPLE_BYTES));
    assign checked  = in_range && (r_pos >= POS_W'(WIN_LAST));
    assign scan     = checked && (r_skip == 3'd0);
    assign c_pos    = FIELD_W'(r_pos) - FIELD_W'(WIN_LAST);

    assign p4 = (w[0] == ZERO_BYTE) && (w[1] == ZERO_BYTE) && (w[2] == ZERO_BYTE)
             && (w[3] == START_BYTE) && ((w[4] & TYPE_MASK) != TYPE_AUD);
    assign p3 = (w[0] == ZERO_BYTE) && (w[1] == ZERO_BYTE) && (w[2] == START_BYTE)
             && ((w[3] & TYPE_MASK) != TYPE_AUD);
    assign found = scan && (p4 || p3);
    assign hdr   = p4 ? w[4] : w[3];

    always_comb begin
        n_pos  = in_range ? r_pos + POS_W'(1) : r_pos;
        n_skip = r_skip;
        n_fcnt = r_fcnt;
        n_open = r_open;
        n_idr  = r_idr;
        if (checked && (r_skip != 3'd0)) begin
            n_skip = r_skip - 3'd1;
        end
        if (found) begin
            n_skip = SKIP_AFTER;
            n_fcnt = r_fcnt + FIELD_W'(1);
            n_open = c_pos + (p4 ? FIELD_W'(4) : FIELD_W'(3));
            if ((hdr & TYPE_MASK) == TYPE_IDR) begin
                n_idr = 1'b1;
            end
        end
    end

    assign key = i_clean_point || n_idr;

    always_comb begin
        o_entry = '0;
        o_entry.has_frag = found && (r_fcnt != '0);
        o_entry.has_end  = i_last_byte;
        if (o_entry.has_frag) begin
            o_entry.frag.valid  = 1'b1;
            o_entry.frag.offset = r_open;
            o_entry.frag.length = c_pos - r_open;
            o_entry.frag.index  = r_fcnt - FIELD_W'(1);
        end
        o_entry.fin.eos = 1'b1;
        o_entry.fin.key = key;
        if (n_fcnt != '0) begin
            o_entry.fin.valid  = 1'b1;
            o_entry.fin.offset = n_open;
            o_entry.fin.length = FIELD_W'(n_pos) - n_open;
            o_entry.fin.index  = n_fcnt - FIELD_W'(1);
            o_entry.fin.count  = n_fcnt;
        end
    end

    assign o_push = i_accept && (o_entry.has_frag || o_entry.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_LAST; k++) begin
                r_win[k] <= '0;
            end
            r_pos  <= '0;
            r_skip <= '0;
            r_fcnt <= '0;
            r_open <= '0;
            r_idr  <= 1'b0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                // Every sample starts from a clean window and counters.
                for (int k = 0; k < WIN_LAST; k++) begin
                    r_win[k] <= '0;
                end
                r_pos  <= '0;
                r_skip <= '0;
                r_fcnt <= '0;
                r_open <= '0;
                r_idr  <= 1'b0;
            end else begin
                if (in_range) begin
                    for (int k = 0; k < WIN_LAST; k++) begin
                        r_win[k] <= w[k+1];
                    end
                end
                r_pos  <= n_pos;
                r_skip <= n_skip;
                r_fcnt <= n_fcnt;
                r_open <= n_open;
                r_idr  <= n_idr;
            end
        end
    end

endmodule

FILE: sv/h264ns_queue.sv
// Short entry queue between the scanning front end and the result back end.
`timescale 1ns / 1ps

module h264ns_queue import h264ns_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry            r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/h264ns_back.sv
// Back end: unpacks queue entries into single results in an output register.
`timescale 1ns / 1ps

module h264ns_back import h264ns_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_entry  i_q_head,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_entry r_ent;
    logic   r_busy;
    logic   r_at_end;
    logic   finishing;

    // The entry is done when its end result, or its only result, is taken.
    assign finishing = r_busy && i_pop && (r_at_end || !r_ent.has_end);
    assign o_q_pop   = !i_q_empty && (!r_busy || finishing);
    assign o_empty   = !r_busy;
    assign o_result  = r_at_end ? r_ent.fin : r_ent.frag;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_at_end <= 1'b0;
        end else if (o_q_pop) begin
            r_busy   <= 1'b1;
            r_at_end <= !i_q_head.has_frag;
        end else if (finishing) begin
            r_busy   <= 1'b0;
        end else if (r_busy && i_pop) begin
            r_at_end <= 1'b1;
        end
    end

endmodule

FILE: sv/h264_start_code_nal_splitter.sv
// Top level of the H.264 Annex B start code scanner and NAL fragment splitter.
// Usage:
//   Input channel: one sample byte per transaction on i_data_byte, with
//   i_last_byte on the final byte and i_clean_point read with that byte.
//   A transaction completes on an edge with i_push high and o_full low.
//   Result channel: while o_empty is low the oldest result is on the o_ ports;
//   it is taken on an edge with i_pop high.
//   A found fragment is reported when the next start code or the end of the
//   sample fixes its length; the last byte always gives an end-of-sample
//   result carrying the key-frame flag and the fragment count.
// Timing: one byte per cycle is accepted while o_full is low. A result passes
//   through the queue and then the back end's output register. A byte that
//   yields two results holds the output until both are taken; a four-entry queue absorbs such bursts.
// Stalls: when i_pop stays low the queue fills and o_full rises, holding off
//   the sender; nothing is dropped.
// Reset: synchronous, active low; clears the scan state and empties the
//   queue and the output register.
`timescale 1ns / 1ps

module h264_start_code_nal_splitter import h264ns_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic               i_clean_point,
    output logic               o_empty,
    input  logic               i_pop,
    output logic               o_fragment_valid,
    output logic [FIELD_W-1:0] o_fragment_offset,
    output logic [FIELD_W-1:0] o_fragment_length,
    output logic [FIELD_W-1:0] o_fragment_index,
    output logic               o_end_of_sample,
    output logic               o_key_frame,
    output logic [FIELD_W-1:0] o_fragment_count
);

    logic    accept;
    logic    push;
    t_entry  entry;
    logic    q_empty;
    t_entry  q_head;
    logic    q_pop;
    t_result result;

    assign accept = i_push && !o_full;

    h264ns_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_clean_point (i_clean_point),
        .o_push        (push),
        .o_entry       (entry)
    );

    h264ns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    h264ns_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (result)
    );

    assign o_fragment_valid  = result.valid;
    assign o_fragment_offset = result.offset;
    assign o_fragment_length = result.length;
    assign o_fragment_index  = result.index;
    assign o_end_of_sample   = result.eos;
    assign o_key_frame       = result.key;
    assign o_fragment_count  = result.count;

endmodule

FILE: tb/sv/h264_start_code_nal_splitter_test.sv
// Self-checking testbench for the H.264 start code NAL splitter.
`timescale 1ns / 1ps

module h264_start_code_nal_splitter_test import h264ns_pkg::*; ();

    localparam int PFX_LONG    = 4;
    localparam int PFX_SHORT   = 3;
    localparam int RANDOM_BYTES = 800;
    localparam int QUIET_TAIL  = 150;

    // Tracks the scan state of the current sample and holds the fragment
    // reports that the block still owes.
    class fragment_scoreboard;
        logic [7:0]         window [6];
        int unsigned        pos;
        logic [2:0]         skip;
        logic [FIELD_W-1:0] found;
        int unsigned        open_off;
        logic               idr;
        t_result            owed_q [$];
        int                 mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            foreach (window[k]) window[k] = 8'h00;
            pos      = 0;
            skip     = 3'd0;
            found    = '0;
            open_off = 0;
            idr      = 1'b0;
        endfunction

        function void log_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        function void note_byte(logic [7:0] b, logic last, logic clean);
            int unsigned c;
            int unsigned pfx;
            t_result     r;
            if (pos < MAX_SAMPLE_BYTES) begin
                for (int k = 0; k < WIN_LAST; k++) window[k] = window[k+1];
                window[WIN_LAST] = b;
                if (pos >= WIN_LAST) begin
                    if (skip != 3'd0) begin
                        skip = skip - 3'd1;
                    end else begin
                        c   = pos - WIN_LAST;
                        pfx = 0;
                        if (window[0] == ZERO_BYTE && window[1] == ZERO_BYTE &&
                            window[2] == ZERO_BYTE && window[3] == START_BYTE &&
                            (window[4] & TYPE_MASK) != TYPE_AUD) begin
                            pfx = PFX_LONG;
                        end else if (window[0] == ZERO_BYTE && window[1] == ZERO_BYTE &&
                                     window[2] == START_BYTE &&
                                     (window[3] & TYPE_MASK) != TYPE_AUD) begin
                            pfx = PFX_SHORT;
                        end
                        if (pfx != 0) begin
                            if ((window[pfx] & TYPE_MASK) == TYPE_IDR) idr = 1'b1;
                            // The new start code closes the fragment that was open.
                            if (found != '0) begin
                                r        = '0;
                                r.valid  = 1'b1;
                                r.offset = FIELD_W'(open_off);
                                r.length = FIELD_W'(c - open_off);
                                r.index  = found - FIELD_W'(1);
                                owed_q.push_back(r);
                            end
                            open_off = c + pfx;
                            found    = found + FIELD_W'(1);
                            skip     = SKIP_AFTER;
                        end
                    end
                end
                pos++;
            end
            if (last) begin
                r     = '0;
                r.eos = 1'b1;
                r.key = clean | idr;
                if (found != '0) begin
                    r.valid  = 1'b1;
                    r.offset = FIELD_W'(open_off);
                    r.length = FIELD_W'(pos - open_off);
                    r.index  = found - FIELD_W'(1);
                    r.count  = found;
                end
                owed_q.push_back(r);
                clear();
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (owed_q.size() == 0) begin
                log_mismatch($sformatf("unexpected result v=%0b off=%0d len=%0d idx=%0d",
                             got.valid, got.offset, got.length, got.index));
                return;
            end
            exp = owed_q.pop_front();
            if (got.valid !== exp.valid || got.offset !== exp.offset ||
                got.length !== exp.length || got.index !== exp.index ||
                got.eos !== exp.eos || got.key !== exp.key || got.count !== exp.count) begin
                log_mismatch($sformatf({"result mismatch: exp v=%0b off=%0d len=%0d idx=%0d ",
                             "eos=%0b key=%0b cnt=%0d, got v=%0b off=%0d len=%0d idx=%0d ",
                             "eos=%0b key=%0b cnt=%0d"},
                             exp.valid, exp.offset, exp.length, exp.index, exp.eos, exp.key,
                             exp.count, got.valid, got.offset, got.length, got.index,
                             got.eos, got.key, got.count));
            end
        endfunction

        function void report_leftovers();
            while (owed_q.size() != 0) begin
                void'(owed_q.pop_front());
                log_mismatch("expected result never arrived");
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_last_byte = 1'b0;
    logic               i_clean_point = 1'b0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic               o_fragment_valid;
    logic [FIELD_W-1:0] o_fragment_offset;
    logic [FIELD_W-1:0] o_fragment_length;
    logic [FIELD_W-1:0] o_fragment_index;
    logic               o_end_of_sample;
    logic               o_key_frame;
    logic [FIELD_W-1:0] o_fragment_count;

    fragment_scoreboard sb;
    logic [7:0]         sample_bytes [$];
    bit                 idle_on = 1'b1;
    int                 bytes_sent = 0;

    h264_start_code_nal_splitter u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_clean_point     (i_clean_point),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_fragment_valid  (o_fragment_valid),
        .o_fragment_offset (o_fragment_offset),
        .o_fragment_length (o_fragment_length),
        .o_fragment_index  (o_fragment_index),
        .o_end_of_sample   (o_end_of_sample),
        .o_key_frame       (o_key_frame),
        .o_fragment_count  (o_fragment_count)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Presents one byte and returns at the edge that completes its transaction.
    task automatic push_byte(input logic [7:0] b, input logic last, input logic clean);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_data_byte   <= b;
        i_last_byte   <= last;
        i_clean_point <= clean;
        do @(posedge i_clk); while (o_full);
        sb.note_byte(b, last, clean);
        bytes_sent++;
    endtask

    // The clean-point flag only matters on the last byte; elsewhere it is noise.
    task automatic send_sample(input logic clean);
        int n;
        n = sample_bytes.size();
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) push_byte(sample_bytes[i], 1'b1, clean);
            else push_byte(sample_bytes[i], 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 3))
            0: return ZERO_BYTE;
            1: return START_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    // A run of NAL units behind 3- or 4-byte prefixes, with zero-heavy payloads
    // so that prefixes also turn up inside the skip window.
    task automatic build_stream_sample();
        logic [4:0] nal_type;
        int         plen;
        sample_bytes = {};
        if ($urandom_range(0, 3) == 0) sample_bytes.push_back(payload_byte());
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 1) sample_bytes.push_back(ZERO_BYTE);
            sample_bytes.push_back(ZERO_BYTE);
            sample_bytes.push_back(ZERO_BYTE);
            sample_bytes.push_back(START_BYTE);
            case ($urandom_range(0, 3))
                0: nal_type = TYPE_IDR[4:0];
                1: nal_type = TYPE_AUD[4:0];
                default: nal_type = 5'($urandom);
            endcase
            sample_bytes.push_back({3'($urandom), nal_type});
            plen = $urandom_range(0, 10);
            repeat (plen) sample_bytes.push_back(payload_byte());
        end
    endtask

    task automatic build_noise_sample();
        sample_bytes = {};
        repeat ($urandom_range(1, 24)) sample_bytes.push_back(payload_byte());
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sample too short to scan; key frame only from the clean-point flag.
        sample_bytes = '{8'hff};
        send_sample(1'b1);
        // Smallest sample that holds a checked 4-byte prefix, with an IDR.
        sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00};
        send_sample(1'b0);
        // Delimiter prefix ignored; a 3-byte prefix at the last checked position.
        sample_bytes = '{8'h00, 8'h00, 8'h01, 8'h09, 8'h00, 8'h00, 8'h01, 8'h41,
                         8'hff, 8'h00};
        send_sample(1'b0);
        // Second prefix found with the last byte, so that byte yields two results.
        sample_bytes = '{8'h00, 8'h00, 8'h01, 8'h41, 8'haa, 8'hbb, 8'h00, 8'h00,
                         8'h01, 8'h25, 8'hcc, 8'h80};
        send_sample(1'b1);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            idle_on = (bytes_sent < RANDOM_BYTES - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) build_stream_sample();
            else build_noise_sample();
            send_sample(1'($urandom_range(0, 1)));
        end
        i_push <= 1'b0;
        idle_on = 1'b0;

        for (int guard = 0; guard < 4000 && sb.owed_q.size() != 0; guard++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Result side: a transaction completes at an edge with pop high and empty low.
    initial begin
        int      stall_left;
        t_result got;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                got.valid  = o_fragment_valid;
                got.offset = o_fragment_offset;
                got.length = o_fragment_length;
                got.index  = o_fragment_index;
                got.eos    = o_end_of_sample;
                got.key    = o_key_frame;
                got.count  = o_fragment_count;
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_pop <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
